[rtl/piecewise_linear_float_function_unit_top_defines.svh]
`ifndef PIECEWISE_LINEAR_FLOAT_FUNCTION_UNIT_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_FLOAT_FUNCTION_UNIT_TOP_DEFINES_SVH

// same-cycle implication
`define PWLF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PWLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/pwlf_pkg.sv]
package pwlf_pkg;

   localparam int SEGMENTS   = 16;
   localparam int BANKS      = 4;
   localparam int BANK_DEPTH = BANKS * SEGMENTS;
   localparam int SEG_W      = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int ADDR_W     = $clog2(BANK_DEPTH);

   localparam logic CMD_EVAL  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] KIND_THRESHOLD = 2'd0;
   localparam logic [1:0] KIND_SLOPE     = 2'd1;
   localparam logic [1:0] KIND_OFFSET    = 2'd2;

   typedef enum logic [1:0] {
      FUNC_SQRT  = 2'd0,
      FUNC_LOG   = 2'd1,
      FUNC_RECIP = 2'd2,
      FUNC_RSQRT = 2'd3
   } func_type;

   localparam logic [31:0] QNAN_BITS      = 32'h7FC0_0000;
   localparam logic [31:0] POS_INF        = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF        = 32'hFF80_0000;
   localparam logic [31:0] LN2_BITS       = 32'h3F31_7218;
   localparam logic [31:0] SQRT2_BITS     = 32'h3FB5_04F3;
   localparam logic [31:0] INV_SQRT2_BITS = 32'h3F35_04F3;

   typedef struct packed {
      logic             thr_en;
      logic             slope_en;
      logic             offset_en;
      logic [1:0]       bank;
      logic [SEG_W-1:0] seg;
      logic [31:0]      word;
   } wr_type;

   typedef struct packed {
      func_type    func;
      logic        sign;
      logic        par;
      logic        special;
      logic [31:0] spec_bits;
      logic [31:0] pow2_bits;
      logic [31:0] fe_bits;
   } ctl_type;

   function automatic logic [ADDR_W-1:0] coef_addr(input logic [1:0] bank,
                                                   input logic [SEG_W-1:0] seg);
      return ADDR_W'(int'(bank) * SEGMENTS + int'(seg));
   endfunction

   function automatic logic fp_is_nan(input logic [31:0] a);
      return a[30:0] > POS_INF[30:0];
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 6'(47 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [5:0] top_bit(input logic [47:0] v);
      return 6'd47 - lzc48(v);
   endfunction

   function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                              input logic [47:0] sig);
      logic signed [11:0] be;
      logic [5:0]         sh;
      logic [95:0]        ext;
      logic [47:0]        shf;
      logic               stk;
      logic               inc;
      logic [7:0]         expf;
      logic [30:0]        mag;
      be = e + 12'sd127;
      if (be >= 12'sd255) return {s, POS_INF[30:0]};
      if (be >= 12'sd1) sh = 6'd0;
      else if (be < -12'sd62) sh = 6'd63;
      else sh = 6'(12'sd1 - be);
      ext = {sig, 48'd0} >> sh;
      shf = ext[95:48];
      stk = (|ext[47:0]) | (|shf[22:0]);
      expf = (be >= 12'sd1) ? be[7:0] : 8'd0;
      inc = shf[23] & (stk | shf[24]);
      mag = {expf, shf[46:24]} + 31'(inc);
      return {s, mag};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic               s;
      logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [7:0]         ea, eb;
      logic [23:0]        ma, mb;
      logic [47:0]        prod, sig;
      logic [5:0]         lz;
      logic signed [11:0] e;
      s = a[31] ^ b[31];
      a_nan = fp_is_nan(a);
      b_nan = fp_is_nan(b);
      a_inf = a[30:0] == POS_INF[30:0];
      b_inf = b[30:0] == POS_INF[30:0];
      a_zero = a[30:0] == 31'd0;
      b_zero = b[30:0] == 31'd0;
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return QNAN_BITS;
      if (a_inf || b_inf) return {s, POS_INF[30:0]};
      if (a_zero || b_zero) return {s, 31'd0};
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      prod = ma * mb;
      lz = lzc48(prod);
      sig = prod << lz;
      e = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd253 - $signed({6'd0, lz});
      return round_pack(s, e, sig);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0]        x, y;
      logic [7:0]         ex, ey, d;
      logic [23:0]        mx, my;
      logic [47:0]        ax, by0, by, r, sig;
      logic [95:0]        ext;
      logic [5:0]         lz;
      logic signed [11:0] e;
      if (fp_is_nan(a) || fp_is_nan(b)) return QNAN_BITS;
      if (a[30:0] == POS_INF[30:0] && b[30:0] == POS_INF[30:0] && a[31] != b[31])
         return QNAN_BITS;
      if (a[30:0] == POS_INF[30:0]) return a;
      if (b[30:0] == POS_INF[30:0]) return b;
      if (a[30:0] < b[30:0]) begin
         x = b;
         y = a;
      end else begin
         x = a;
         y = b;
      end
      ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      mx = {x[30:23] != 8'd0, x[22:0]};
      my = {y[30:23] != 8'd0, y[22:0]};
      d = ex - ey;
      ax = {1'b0, mx, 23'd0};
      by0 = {1'b0, my, 23'd0};
      ext = {by0, 48'd0} >> ((d > 8'd63) ? 6'd63 : d[5:0]);
      by = ext[95:48] | {47'd0, |ext[47:0]};
      r = (x[31] == y[31]) ? ax + by : ax - by;
      if (r == 48'd0) return {x[31] & y[31], 31'd0};
      lz = lzc48(r);
      sig = r << lz;
      e = $signed({4'd0, ex}) - 12'sd126 - $signed({6'd0, lz});
      return round_pack(x[31], e, sig);
   endfunction

   function automatic logic [15:0] to_half(input logic [31:0] b);
      logic [15:0] sgn, h;
      logic [7:0]  e;
      logic [22:0] m;
      logic [12:0] rem;
      logic [23:0] mm, remw, half;
      logic [4:0]  shift;
      sgn = {b[31], 15'd0};
      e = b[30:23];
      m = b[22:0];
      if (b[30:0] > POS_INF[30:0]) return sgn | 16'h7E00;
      if (e >= 8'd143) return sgn | 16'h7C00;
      if (e >= 8'd113) begin
         h = {1'b0, 5'(e - 8'd112), m[22:13]};
         rem = m[12:0];
         if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) h = h + 16'd1;
         return sgn | h;
      end
      if (e < 8'd102) return sgn;
      mm = {1'b1, m};
      shift = 5'(8'd126 - e);
      h = 16'(mm >> shift);
      remw = mm & ((24'd1 << shift) - 24'd1);
      half = 24'd1 << (shift - 5'd1);
      if (remw > half || (remw == half && h[0])) h = h + 16'd1;
      return sgn | h;
   endfunction

   function automatic logic [31:0] from_half(input logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [9:0]  fr;
      logic [5:0]  p;
      logic [22:0] fs;
      sgn = {h[15], 31'd0};
      ex = h[14:10];
      fr = h[9:0];
      if (ex == 5'd31) return sgn | POS_INF | {9'd0, fr, 13'd0};
      if (ex != 5'd0) return sgn | {1'b0, 8'(ex) + 8'd112, fr, 13'd0};
      if (fr == 10'd0) return sgn;
      p = top_bit({38'd0, fr});
      fs = 23'({13'd0, fr} << (6'd23 - p));
      return sgn | {1'b0, 8'(p) + 8'd103, fs};
   endfunction

   function automatic logic [31:0] int_to_fp(input logic signed [8:0] e);
      logic        s;
      logic [7:0]  mag;
      logic [5:0]  p;
      logic [22:0] fs;
      if (e == 9'sd0) return 32'd0;
      s = e[8];
      mag = s ? 8'(-e) : 8'(e);
      p = top_bit({40'd0, mag});
      fs = 23'({15'd0, mag} << (6'd23 - p));
      return {s, 8'(p) + 8'd127, fs};
   endfunction

   function automatic logic [31:0] pow2_bits(input logic signed [9:0] n);
      if (n > 10'sd127) return POS_INF;
      if (n >= -10'sd126) return {1'b0, 8'(n + 10'sd127), 23'd0};
      if (n >= -10'sd149) return 32'd1 << 5'(n + 10'sd149);
      return 32'd0;
   endfunction

endpackage

[rtl/pwlf_seg_sel.sv]
module pwlf_seg_sel import pwlf_pkg::*; (
   input  logic             clock,
   input  logic             adv,
   input  wr_type           wr,
   input  logic [1:0]       rd_bank,
   input  logic [31:0]      m,
   output logic [SEG_W-1:0] seg_idx
);

   logic [31:0]         thr_ram [BANKS][SEGMENTS];
   logic [31:0]         row_ff [SEGMENTS];
   logic [SEGMENTS-1:0] hit;
   logic                found;

   // one row per bank, lane write per segment
   always_ff @(posedge clock) begin
      if (wr.thr_en) thr_ram[wr.bank][wr.seg] <= wr.word;
      if (adv) row_ff <= thr_ram[rd_bank];
   end

   // m is positive, so the float compare is an integer compare on non-nan positives
   always_comb begin
      for (int i = 0; i < SEGMENTS; i++) begin
         hit[i] = !row_ff[i][31] && (row_ff[i][30:0] >= m[30:0]) &&
                  (row_ff[i][30:0] <= POS_INF[30:0]);
      end
   end

   always_comb begin
      seg_idx = SEG_W'(SEGMENTS - 1);
      found = 1'b0;
      for (int i = 0; i < SEGMENTS; i++) begin
         if (!found && hit[i]) begin
            seg_idx = SEG_W'(i);
            found = 1'b1;
         end
      end
   end

endmodule

[rtl/pwlf_coef_mem.sv]
module pwlf_coef_mem import pwlf_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  wr_type            wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       slope,
   output logic [31:0]       offset
);

   logic [31:0]       slope_ram [BANK_DEPTH];
   logic [31:0]       offset_ram [BANK_DEPTH];
   logic [31:0]       slope_ff;
   logic [31:0]       offset_ff;
   logic [ADDR_W-1:0] wr_addr;

   assign wr_addr = coef_addr(wr.bank, wr.seg);

   always_ff @(posedge clock) begin
      if (wr.slope_en) slope_ram[wr_addr] <= wr.word;
      if (wr.offset_en) offset_ram[wr_addr] <= wr.word;
      if (adv) begin
         slope_ff <= slope_ram[rd_addr];
         offset_ff <= offset_ram[rd_addr];
      end
   end

   assign slope = slope_ff;
   assign offset = offset_ff;

endmodule

[rtl/pwlf_arith.sv]
module pwlf_arith import pwlf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  ctl_type     in_ctl,
   input  logic [31:0] m,
   input  logic [31:0] slope,
   input  logic [31:0] offset,
   output logic        out_valid,
   output logic [31:0] out_bits
);

   logic        v3_ff, v4_ff, v5_ff, v6_ff;
   ctl_type     ctl3_ff, ctl4_ff, ctl5_ff, ctl6_ff;
   logic [31:0] prod3_ff, off3_ff, eln3_ff;
   logic [31:0] sum4_ff, eln4_ff;
   logic [31:0] core5_ff, eln5_ff;
   logic [31:0] r6_ff;
   logic [31:0] r6_in;
   logic [31:0] scale;
   logic [31:0] r_fin;
   logic [31:0] r_canon;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   assign r6_in = (ctl5_ff.func == FUNC_LOG) ? fp_add(core5_ff, eln5_ff)
                                             : fp_mul(core5_ff, ctl5_ff.pow2_bits);

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl3_ff <= in_ctl;
         prod3_ff <= fp_mul(slope, m);
         off3_ff <= offset;
         eln3_ff <= fp_mul(in_ctl.fe_bits, LN2_BITS);
         ctl4_ff <= ctl3_ff;
         sum4_ff <= fp_add(prod3_ff, off3_ff);
         eln4_ff <= eln3_ff;
         ctl5_ff <= ctl4_ff;
         core5_ff <= from_half(to_half(sum4_ff));
         eln5_ff <= eln4_ff;
         ctl6_ff <= ctl5_ff;
         r6_ff <= r6_in;
      end
   end

   // odd exponent picks up the root-two factor
   always_comb begin
      scale = (ctl6_ff.func == FUNC_SQRT) ? SQRT2_BITS : INV_SQRT2_BITS;
      if ((ctl6_ff.func == FUNC_SQRT || ctl6_ff.func == FUNC_RSQRT) && ctl6_ff.par)
         r_fin = fp_mul(r6_ff, scale);
      else
         r_fin = r6_ff;
      r_canon = fp_is_nan(r_fin) ? QNAN_BITS : r_fin;
      if (ctl6_ff.special)
         out_bits = ctl6_ff.spec_bits;
      else if (ctl6_ff.func == FUNC_RECIP)
         out_bits = {ctl6_ff.sign, r_canon[30:0]};
      else
         out_bits = r_canon;
   end

   assign out_valid = v6_ff;

endmodule

[rtl/piecewise_linear_float_function_unit_top.sv]
// channel  dir  handshake              payload
// req      in   req_valid, req_stall   cmd func operand_bits segment coef_kind table_word
// rsp      out  rsp_valid, rsp_stall   result_bits
//
// one beat per cycle on each side while the side is not stalled; an evaluate beat reaches rsp through the stages below
// depth: row read on the accept edge, coefficient ram read, four float stages, output reg
// a table write beat lands in the rams on the cycle it is taken and gives no rsp beat
// reset clears the pipeline valid bits only; table contents are unknown until written
// a result arriving while rsp is stalled parks in a skid register
// a full skid register raises req_stall and freezes every stage until rsp drains

`include "piecewise_linear_float_function_unit_top_defines.svh"

module piecewise_linear_float_function_unit_top import pwlf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_operand_bits,
   input  logic [3:0]  req_segment,
   input  logic [1:0]  req_coef_kind,
   input  logic [31:0] req_table_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_bits
);

   logic              adv;
   logic              accept;
   logic              wr_go;
   wr_type            wr;
   ctl_type           ctl0;
   logic [31:0]       m0;
   logic              is_nan, is_inf, is_zero, sign0;
   logic [7:0]        ex0;
   logic [22:0]       fr0;
   logic [5:0]        p0;
   logic signed [8:0] e0, k0;
   logic signed [9:0] n0;
   logic              v1_ff, v2_ff;
   ctl_type           ctl1_ff, ctl2_ff;
   logic [31:0]       m1_ff, m2_ff;
   logic [SEG_W-1:0]  seg_idx;
   logic [31:0]       slope, offset;
   logic              arith_valid;
   logic [31:0]       arith_bits;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_result_bits_ff;
   logic              skid_valid_ff;
   logic [31:0]       skid_bits_ff;

   assign adv = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept = req_valid && adv;

   assign wr_go = accept && req_cmd == CMD_WRITE && int'(req_segment) < SEGMENTS;
   always_comb begin
      wr.thr_en = wr_go && req_coef_kind == KIND_THRESHOLD;
      wr.slope_en = wr_go && req_coef_kind == KIND_SLOPE;
      wr.offset_en = wr_go && req_coef_kind == KIND_OFFSET;
      wr.bank = req_func;
      wr.seg = SEG_W'(req_segment);
      wr.word = req_table_word;
   end

   // operand decode, special values and mantissa split
   always_comb begin
      sign0 = req_operand_bits[31];
      is_nan = fp_is_nan(req_operand_bits);
      is_inf = req_operand_bits[30:0] == POS_INF[30:0];
      is_zero = req_operand_bits[30:0] == 31'd0;
      ctl0.func = func_type'(req_func);
      ctl0.sign = sign0;
      ctl0.special = 1'b0;
      ctl0.spec_bits = QNAN_BITS;
      if (ctl0.func != FUNC_RECIP && (is_nan || (sign0 && !is_zero))) begin
         ctl0.special = 1'b1;
      end else begin
         case (ctl0.func)
            FUNC_SQRT: begin
               if (is_zero || is_inf) begin
                  ctl0.special = 1'b1;
                  ctl0.spec_bits = req_operand_bits;
               end
            end
            FUNC_LOG: begin
               if (is_zero) begin
                  ctl0.special = 1'b1;
                  ctl0.spec_bits = NEG_INF;
               end else if (is_inf) begin
                  ctl0.special = 1'b1;
                  ctl0.spec_bits = POS_INF;
               end
            end
            FUNC_RECIP: begin
               if (is_nan) begin
                  ctl0.special = 1'b1;
                  ctl0.spec_bits = req_operand_bits;
               end else if (is_zero) begin
                  ctl0.special = 1'b1;
                  ctl0.spec_bits = {sign0, POS_INF[30:0]};
               end else if (is_inf) begin
                  ctl0.special = 1'b1;
                  ctl0.spec_bits = {sign0, 31'd0};
               end
            end
            FUNC_RSQRT: begin
               if (is_zero) begin
                  ctl0.special = 1'b1;
                  ctl0.spec_bits = POS_INF;
               end else if (is_inf) begin
                  ctl0.special = 1'b1;
                  ctl0.spec_bits = 32'd0;
               end
            end
         endcase
      end
      ex0 = req_operand_bits[30:23];
      fr0 = req_operand_bits[22:0];
      p0 = top_bit({25'd0, fr0});
      if (ex0 != 8'd0) begin
         m0 = {9'h07F, fr0};
         e0 = $signed({1'b0, ex0}) - 9'sd127;
      end else begin
         m0 = {9'h07F, 23'(fr0 << (6'd23 - p0))};
         e0 = $signed({3'd0, p0}) - 9'sd149;
      end
      k0 = e0 >>> 1;
      ctl0.par = e0[0];
      if (ctl0.func == FUNC_SQRT) n0 = 10'(k0);
      else if (ctl0.func == FUNC_RSQRT) n0 = -10'(k0);
      else n0 = -10'(e0);
      ctl0.pow2_bits = pow2_bits(n0);
      ctl0.fe_bits = int_to_fp(e0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept && req_cmd == CMD_EVAL;
         v2_ff <= v1_ff;
      end
   end

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && rsp_stall) begin
         skid_valid_ff <= arith_valid;
      end else begin
         rsp_valid_ff <= arith_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) rsp_result_bits_ff <= skid_bits_ff;
      end else if (rsp_valid_ff && rsp_stall) begin
         skid_bits_ff <= arith_bits;
      end else begin
         rsp_result_bits_ff <= arith_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl1_ff <= ctl0;
         m1_ff <= m0;
         ctl2_ff <= ctl1_ff;
         m2_ff <= m1_ff;
      end
   end

   pwlf_seg_sel u_seg_sel (
      .clock   (clock),
      .adv     (adv),
      .wr      (wr),
      .rd_bank (req_func),
      .m       (m1_ff),
      .seg_idx (seg_idx)
   );

   pwlf_coef_mem u_coef_mem (
      .clock   (clock),
      .adv     (adv),
      .wr      (wr),
      .rd_addr (coef_addr(ctl1_ff.func, seg_idx)),
      .slope   (slope),
      .offset  (offset)
   );

   pwlf_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v2_ff),
      .in_ctl    (ctl2_ff),
      .m         (m2_ff),
      .slope     (slope),
      .offset    (offset),
      .out_valid (arith_valid),
      .out_bits  (arith_bits)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_bits = rsp_result_bits_ff;

   `PWLF_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff,
                      "skid register full with an empty output register")
   `PWLF_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !rsp_stall, !skid_valid_ff,
                     "skid register did not drain")
   `PWLF_ASSERT_IMPLY(a_empty_open, clock, reset, !rsp_valid_ff, !req_stall,
                      "request stalled with an empty output register")
   `PWLF_ASSERT_NEXT(a_eval_enters, clock, reset, accept && req_cmd == CMD_EVAL, v1_ff,
                     "evaluate beat did not enter the pipeline")
   `PWLF_ASSERT_NEXT(a_write_silent, clock, reset, accept && req_cmd == CMD_WRITE, !v1_ff,
                     "table write beat produced a pipeline item")

endmodule
